// ===== rtl/bmprgba_pkg.sv =====
// shared types, status codes and sizing constants of the bmp to rgba decoder
package bmprgba_pkg;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // result kinds
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // final status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_SHORT_HDR  = 3'd1;
   localparam logic [2:0] STATUS_BAD_MARKER = 3'd2;
   localparam logic [2:0] STATUS_BAD_DEPTH  = 3'd3;
   localparam logic [2:0] STATUS_LOW_OFFSET = 3'd4;
   localparam logic [2:0] STATUS_TOO_SMALL  = 3'd5;

   // one queue entry: up to one pixel and one status from a single input word
   typedef struct packed {
      logic        has_pixel;
      logic        has_status;
      logic [2:0]  status;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] width;
      logic [15:0] height;
   } event_type;

   // queue fill flags seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_flags_type;

endpackage

// ===== rtl/bmprgba_front.sv =====
// front end: header capture, scanline walk and status check, one byte per cycle while the queue is not full
module bmprgba_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_byte,
   output logic                         push_valid,
   output bmprgba_pkg::event_type       push_data,
   input  bmprgba_pkg::queue_flags_type queue_flags
);

   // header byte positions
   localparam logic [31:0] HEADER_BYTES = 32'd54;
   localparam logic [15:0] MIN_OFFSET   = 16'd54;
   localparam logic [5:0]  POS_MARK0    = 6'd0;
   localparam logic [5:0]  POS_MARK1    = 6'd1;
   localparam logic [5:0]  POS_OFS_LO   = 6'd10;
   localparam logic [5:0]  POS_OFS_HI   = 6'd11;
   localparam logic [5:0]  POS_WID_LO   = 6'd18;
   localparam logic [5:0]  POS_WID_HI   = 6'd19;
   localparam logic [5:0]  POS_HGT_LO   = 6'd22;
   localparam logic [5:0]  POS_HGT_HI   = 6'd23;
   localparam logic [5:0]  POS_DEPTH    = 6'd28;
   localparam logic [7:0]  CHAR_B       = 8'h42;
   localparam logic [7:0]  CHAR_M       = 8'h4D;
   localparam logic [7:0]  DEPTH_24     = 8'd24;
   localparam logic [7:0]  DEPTH_32     = 8'd32;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

   logic [31:0] pos_ff, pos_in;
   logic        marker_good_ff, marker_good_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic [16:0] file_row_ff, file_row_in;
   logic [17:0] byte_in_row_ff, byte_in_row_in;
   logic [15:0] column_ff, column_in;
   logic [23:0] held_ff, held_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [17:0] row_bytes_ff, row_bytes_in;
   logic [33:0] image_bytes_ff, image_bytes_in;

   logic        accept;
   logic        four_chan;
   logic        depth_good;
   logic        header_good;
   logic        pixel_active;
   logic        pixel_emit;
   logic [17:0] raw_row;
   logic [17:0] row_next;
   logic [32:0] file_size;
   logic [34:0] needed_size;
   logic [2:0]  status;
   logic [7:0]  red;
   logic [7:0]  alpha;

   assign req_ready = !queue_flags.full;
   assign accept    = req_valid && req_ready;

   // channel count and padded scanline length
   assign four_chan   = (depth_ff == DEPTH_32);
   assign depth_good  = (depth_ff == DEPTH_24) || four_chan;
   assign header_good = marker_good_ff && depth_good && (offset_ff >= MIN_OFFSET);
   assign raw_row     = four_chan ? {width_ff, 2'b00}
                                  : ({1'b0, width_ff, 1'b0} + {2'b00, width_ff});
   assign row_bytes_in   = (raw_row + 18'd3) & ~18'd3;
   assign image_bytes_in = row_bytes_ff * height_ff;

   // size check pipeline settles long before the header ends
   always_ff @(posedge clock) begin
      row_bytes_ff   <= row_bytes_in;
      image_bytes_ff <= image_bytes_in;
   end

   // pixel walk conditions
   assign pixel_active = (pos_ff >= HEADER_BYTES) && header_good
                         && (pos_ff >= {16'd0, offset_ff}) && (width_ff != 16'd0)
                         && (file_row_ff < {1'b0, height_ff});
   assign pixel_emit   = pixel_active && (column_ff < width_ff)
                         && (held_count_ff == (four_chan ? 2'd3 : 2'd2));
   assign red          = four_chan ? held_ff[23:16] : req_data_byte;
   assign alpha        = four_chan ? req_data_byte : ALPHA_OPAQUE;
   assign row_next     = byte_in_row_ff + 18'd1;

   // final status
   assign file_size   = {1'b0, pos_ff} + 33'd1;
   assign needed_size = {19'd0, offset_ff} + {1'b0, image_bytes_ff};
   always_comb begin
      if (file_size < {1'b0, HEADER_BYTES}) begin
         status = bmprgba_pkg::STATUS_SHORT_HDR;
      end else if (!marker_good_ff) begin
         status = bmprgba_pkg::STATUS_BAD_MARKER;
      end else if (!depth_good) begin
         status = bmprgba_pkg::STATUS_BAD_DEPTH;
      end else if (offset_ff < MIN_OFFSET) begin
         status = bmprgba_pkg::STATUS_LOW_OFFSET;
      end else if ({2'b00, file_size} < needed_size) begin
         status = bmprgba_pkg::STATUS_TOO_SMALL;
      end else begin
         status = bmprgba_pkg::STATUS_OK;
      end
   end

   // next state of the byte walk
   always_comb begin
      pos_in         = pos_ff;
      marker_good_in = marker_good_ff;
      offset_in      = offset_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      depth_in       = depth_ff;
      file_row_in    = file_row_ff;
      byte_in_row_in = byte_in_row_ff;
      column_in      = column_ff;
      held_in        = held_ff;
      held_count_in  = held_count_ff;
      if (pos_ff < HEADER_BYTES) begin
         case (pos_ff[5:0])
            POS_MARK0:  if (req_data_byte != CHAR_B) marker_good_in = 1'b0;
            POS_MARK1:  if (req_data_byte != CHAR_M) marker_good_in = 1'b0;
            POS_OFS_LO: offset_in[7:0]  = req_data_byte;
            POS_OFS_HI: offset_in[15:8] = req_data_byte;
            POS_WID_LO: width_in[7:0]   = req_data_byte;
            POS_WID_HI: width_in[15:8]  = req_data_byte;
            POS_HGT_LO: height_in[7:0]  = req_data_byte;
            POS_HGT_HI: height_in[15:8] = req_data_byte;
            POS_DEPTH:  depth_in        = req_data_byte;
            default:    ;
         endcase
      end else if (pixel_active) begin
         if (column_ff < width_ff) begin
            if (pixel_emit) begin
               held_in       = 24'd0;
               held_count_in = 2'd0;
               column_in     = column_ff + 16'd1;
            end else begin
               case (held_count_ff)
                  2'd0:    held_in[7:0]   = req_data_byte;
                  2'd1:    held_in[15:8]  = req_data_byte;
                  default: held_in[23:16] = req_data_byte;
               endcase
               held_count_in = held_count_ff + 2'd1;
            end
         end
         if (row_next >= row_bytes_ff) begin
            byte_in_row_in = 18'd0;
            column_in      = 16'd0;
            held_count_in  = 2'd0;
            held_in        = 24'd0;
            file_row_in    = file_row_ff + 17'd1;
         end else begin
            byte_in_row_in = row_next;
         end
      end
      if (pos_ff != 32'hFFFF_FFFF) begin
         pos_in = pos_ff + 32'd1;
      end
   end

   // queue entry for this word
   always_comb begin
      push_valid           = accept && (pixel_emit || req_last_byte);
      push_data.has_pixel  = pixel_emit;
      push_data.has_status = req_last_byte;
      push_data.status     = status;
      push_data.pixel_x    = column_ff;
      push_data.pixel_y    = height_ff - file_row_ff[15:0] - 16'd1;
      push_data.red        = red;
      push_data.green      = held_ff[15:8];
      push_data.blue       = held_ff[7:0];
      push_data.alpha      = alpha;
      push_data.width      = width_in;
      push_data.height     = height_in;
   end

   // state registers, cleared again after the last byte of a file
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff         <= 32'd0;
         marker_good_ff <= 1'b1;
         offset_ff      <= 16'd0;
         width_ff       <= 16'd0;
         height_ff      <= 16'd0;
         depth_ff       <= 8'd0;
         file_row_ff    <= 17'd0;
         byte_in_row_ff <= 18'd0;
         column_ff      <= 16'd0;
         held_ff        <= 24'd0;
         held_count_ff  <= 2'd0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         marker_good_ff <= marker_good_in;
         offset_ff      <= offset_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         depth_ff       <= depth_in;
         file_row_ff    <= file_row_in;
         byte_in_row_ff <= byte_in_row_in;
         column_ff      <= column_in;
         held_ff        <= held_in;
         held_count_ff  <= held_count_in;
      end
   end

endmodule

// ===== rtl/bmprgba_queue.sv =====
// short fifo of result entries between front and back
module bmprgba_queue #(
   parameter int DEPTH = bmprgba_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  bmprgba_pkg::event_type       push_data,
   input  logic                         pop_ready,
   output bmprgba_pkg::event_type       pop_data,
   output bmprgba_pkg::queue_flags_type queue_flags
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bmprgba_pkg::event_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign queue_flags.full      = (count_ff == CNT_W'(DEPTH));
   assign queue_flags.not_empty = (count_ff != '0);
   assign do_push  = push_valid && !queue_flags.full;
   assign do_pop   = pop_ready && queue_flags.not_empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/bmprgba_back.sv =====
// back end: output register that sends the pixel and then the status of an entry
module bmprgba_back (
   input  logic                         clock,
   input  logic                         reset,
   input  bmprgba_pkg::queue_flags_type queue_flags,
   input  bmprgba_pkg::event_type       pop_data,
   output logic                         pop_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_item_kind,
   output logic [2:0]                   rsp_status,
   output logic [15:0]                  rsp_pixel_x,
   output logic [15:0]                  rsp_pixel_y,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue,
   output logic [7:0]                   rsp_alpha,
   output logic [15:0]                  rsp_width_out,
   output logic [15:0]                  rsp_height_out
);

   bmprgba_pkg::event_type cur_ff;
   logic pix_pend_ff, pix_pend_in;
   logic stat_pend_ff, stat_pend_in;
   logic fire;
   logic entry_done;
   logic take;

   assign rsp_valid  = pix_pend_ff || stat_pend_ff;
   assign fire       = rsp_valid && rsp_ready;
   assign entry_done = fire && (!pix_pend_ff || !stat_pend_ff);
   assign pop_ready  = !rsp_valid || entry_done;
   assign take       = pop_ready && queue_flags.not_empty;

   // pending flags
   always_comb begin
      pix_pend_in  = pix_pend_ff;
      stat_pend_in = stat_pend_ff;
      if (take) begin
         pix_pend_in  = pop_data.has_pixel;
         stat_pend_in = pop_data.has_status;
      end else if (fire) begin
         if (pix_pend_ff) begin
            pix_pend_in = 1'b0;
         end else begin
            stat_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_pend_ff  <= 1'b0;
         stat_pend_ff <= 1'b0;
      end else begin
         pix_pend_ff  <= pix_pend_in;
         stat_pend_ff <= stat_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= pop_data;
      end
   end

   // pixel word first, then the status word with zeroed pixel fields
   always_comb begin
      rsp_width_out  = cur_ff.width;
      rsp_height_out = cur_ff.height;
      if (pix_pend_ff) begin
         rsp_item_kind = bmprgba_pkg::KIND_PIXEL;
         rsp_status    = bmprgba_pkg::STATUS_OK;
         rsp_pixel_x   = cur_ff.pixel_x;
         rsp_pixel_y   = cur_ff.pixel_y;
         rsp_red       = cur_ff.red;
         rsp_green     = cur_ff.green;
         rsp_blue      = cur_ff.blue;
         rsp_alpha     = cur_ff.alpha;
      end else begin
         rsp_item_kind = bmprgba_pkg::KIND_STATUS;
         rsp_status    = cur_ff.status;
         rsp_pixel_x   = 16'd0;
         rsp_pixel_y   = 16'd0;
         rsp_red       = 8'd0;
         rsp_green     = 8'd0;
         rsp_blue      = 8'd0;
         rsp_alpha     = 8'd0;
      end
   end

endmodule

// ===== rtl/bmp_to_rgba_decoder_unit.sv =====
// top level of the streaming 24/32-bit bmp to rgba decoder
// The block takes a bmp file one byte per word on req_, with req_last_byte on the final
// byte, and returns one rsp_ word per completed pixel (column, top-down row, rgba) and
// one status word after the last byte; pixels of a file whose status is not ok are void.
// It accepts one byte every cycle while the queue is not full: the front end does all
// header capture and scanline counting for a byte in the cycle it is accepted, and the
// back end sends one word per cycle while rsp_ready is high, so the last byte of a file,
// which can yield a pixel and the status, costs the back end two words that the queue of
// QUEUE_DEPTH entries between them absorbs. req_ready drops only while that queue is full,
// which happens only when rsp_ready is held low. A byte is classified in the cycle it is
// accepted and its entry is written into the queue at that edge; the back end then loads
// the entry into its output register, from which its first word is offered. Between files
// no gap is needed; state returns to reset after each last byte.
module bmp_to_rgba_decoder_unit #(
   parameter int QUEUE_DEPTH = bmprgba_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [15:0] rsp_width_out,
   output logic [15:0] rsp_height_out
);

   logic                         push_valid;
   bmprgba_pkg::event_type       push_data;
   logic                         pop_ready;
   bmprgba_pkg::event_type       pop_data;
   bmprgba_pkg::queue_flags_type queue_flags;

   // byte walk and classification
   bmprgba_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_flags   (queue_flags)
   );

   // decoupling queue
   bmprgba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .queue_flags (queue_flags)
   );

   // result sender
   bmprgba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_flags    (queue_flags),
      .pop_data       (pop_data),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_status     (rsp_status),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_width_out  (rsp_width_out),
      .rsp_height_out (rsp_height_out)
   );

   // no entry is ever dropped at a full queue
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_flags.full)
      else $error("queue overflow");

   // pixel words always carry the ok code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item_kind == bmprgba_pkg::KIND_PIXEL))
      |-> (rsp_status == bmprgba_pkg::STATUS_OK))
      else $error("pixel word with a status code");

   // status words never carry a code beyond too small
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item_kind == bmprgba_pkg::KIND_STATUS))
      |-> (rsp_status <= bmprgba_pkg::STATUS_TOO_SMALL))
      else $error("status code out of range");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the bmp to rgba decoder unit
module tb_top;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 10;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 16;

   // bmp header layout
   localparam int HDR_BYTES  = 54;
   localparam int POS_MARK0  = 0;
   localparam int POS_MARK1  = 1;
   localparam int POS_OFS_LO = 10;
   localparam int POS_OFS_HI = 11;
   localparam int POS_WID_LO = 18;
   localparam int POS_WID_HI = 19;
   localparam int POS_HGT_LO = 22;
   localparam int POS_HGT_HI = 23;
   localparam int POS_DEPTH  = 28;

   localparam logic [7:0] MARK_B       = 8'h42;
   localparam logic [7:0] MARK_M       = 8'h4D;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam logic [7:0] DEPTH_16     = 8'd16;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_pixel_x;
   logic [15:0] rsp_pixel_y;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [15:0] rsp_width_out;
   logic [15:0] rsp_height_out;

   // one expected output word
   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [15:0] px;
      logic [15:0] py;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] width;
      logic [15:0] height;
   } rgba_word_type;

   rgba_word_type pending_words[$];
   logic [7:0]    image_bytes[$];
   int            bytes_sent = 0;
   int            error_count = 0;
   int            quiet_cycles = 0;
   int unsigned   req_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   // decoder state mirror
   logic [31:0] byte_pos;
   logic        marker_ok;
   logic [15:0] pix_offset;
   logic [15:0] img_width;
   logic [15:0] img_height;
   logic [7:0]  bpp;
   logic [16:0] scan_row;
   logic [17:0] scan_byte;
   logic [15:0] scan_col;
   logic [23:0] held_bytes;
   logic [1:0]  held_count;

   bmp_to_rgba_decoder_unit u_top (.*);

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic depth_supported();
      return bpp == DEPTH_24 || bpp == DEPTH_32;
   endfunction

   function automatic int unsigned bytes_per_pixel();
      return (bpp == DEPTH_32) ? 4 : 3;
   endfunction

   // scanline length rounded up to whole 32-bit words
   function automatic int unsigned padded_row_len();
      int unsigned raw;
      raw = img_width * bytes_per_pixel();
      return (raw + 3) & ~32'd3;
   endfunction

   function automatic void clear_decoder_state();
      byte_pos   = '0;
      marker_ok  = 1'b1;
      pix_offset = '0;
      img_width  = '0;
      img_height = '0;
      bpp        = '0;
      scan_row   = '0;
      scan_byte  = '0;
      scan_col   = '0;
      held_bytes = '0;
      held_count = '0;
   endfunction

   // advance the decoder mirror by one byte and queue the words it yields
   function automatic void model_bmp_byte(input logic [7:0] b, input logic last);
      rgba_word_type   w;
      logic [31:0]     pos;
      int unsigned     n_ch;
      logic [63:0]     file_size;
      logic [63:0]     needed;
      pos = byte_pos;
      if (pos < HDR_BYTES) begin
         case (pos)
            POS_MARK0: if (b != MARK_B) marker_ok = 1'b0;
            POS_MARK1: if (b != MARK_M) marker_ok = 1'b0;
            POS_OFS_LO: pix_offset[7:0] = b;
            POS_OFS_HI: pix_offset[15:8] = b;
            POS_WID_LO: img_width[7:0] = b;
            POS_WID_HI: img_width[15:8] = b;
            POS_HGT_LO: img_height[7:0] = b;
            POS_HGT_HI: img_height[15:8] = b;
            POS_DEPTH: bpp = b;
            default: ;
         endcase
      end else if (marker_ok && depth_supported() && pix_offset >= HDR_BYTES &&
                   pos >= pix_offset && img_width != 0 && scan_row < img_height) begin
         n_ch = bytes_per_pixel();
         if (scan_col < img_width) begin
            if (held_count == n_ch - 1) begin
               w        = '0;
               w.kind   = bmprgba_pkg::KIND_PIXEL;
               w.status = bmprgba_pkg::STATUS_OK;
               w.px     = scan_col;
               w.py     = img_height - scan_row[15:0] - 16'd1;
               w.red    = (n_ch == 3) ? b : held_bytes[23:16];
               w.green  = held_bytes[15:8];
               w.blue   = held_bytes[7:0];
               w.alpha  = (n_ch == 3) ? ALPHA_OPAQUE : b;
               w.width  = img_width;
               w.height = img_height;
               pending_words.push_back(w);
               held_count = '0;
               held_bytes = '0;
               scan_col++;
            end else begin
               held_bytes[8 * held_count +: 8] = b;
               held_count++;
            end
         end
         // end of scanline, padding included
         scan_byte++;
         if (scan_byte >= padded_row_len()) begin
            scan_byte  = '0;
            scan_col   = '0;
            held_count = '0;
            held_bytes = '0;
            scan_row++;
         end
      end
      if (byte_pos != '1) byte_pos++;
      // closing status word, then back to reset for the next file
      if (last) begin
         file_size = {32'd0, pos} + 64'd1;
         needed    = 64'(pix_offset) + 64'(padded_row_len()) * 64'(img_height);
         w         = '0;
         w.kind    = bmprgba_pkg::KIND_STATUS;
         if (file_size < HDR_BYTES) w.status = bmprgba_pkg::STATUS_SHORT_HDR;
         else if (!marker_ok) w.status = bmprgba_pkg::STATUS_BAD_MARKER;
         else if (!depth_supported()) w.status = bmprgba_pkg::STATUS_BAD_DEPTH;
         else if (pix_offset < HDR_BYTES) w.status = bmprgba_pkg::STATUS_LOW_OFFSET;
         else if (file_size < needed) w.status = bmprgba_pkg::STATUS_TOO_SMALL;
         else w.status = bmprgba_pkg::STATUS_OK;
         w.width  = img_width;
         w.height = img_height;
         pending_words.push_back(w);
         clear_decoder_state();
      end
   endfunction

   function automatic logic field_differs(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // compare one output word against the oldest expectation
   function automatic void check_rgba_word();
      rgba_word_type want;
      logic          bad;
      if (pending_words.size() == 0) begin
         $error("word with nothing expected: kind %0d status %0d x %0d y %0d",
                rsp_item_kind, rsp_status, rsp_pixel_x, rsp_pixel_y);
         error_count++;
      end else begin
         want = pending_words.pop_front();
         bad  = 1'b0;
         bad |= field_differs("item_kind", 16'(want.kind), 16'(rsp_item_kind));
         bad |= field_differs("status", 16'(want.status), 16'(rsp_status));
         bad |= field_differs("pixel_x", want.px, rsp_pixel_x);
         bad |= field_differs("pixel_y", want.py, rsp_pixel_y);
         bad |= field_differs("red", 16'(want.red), 16'(rsp_red));
         bad |= field_differs("green", 16'(want.green), 16'(rsp_green));
         bad |= field_differs("blue", 16'(want.blue), 16'(rsp_blue));
         bad |= field_differs("alpha", 16'(want.alpha), 16'(rsp_alpha));
         bad |= field_differs("width_out", want.width, rsp_width_out);
         bad |= field_differs("height_out", want.height, rsp_height_out);
         if (bad) error_count++;
      end
   endfunction

   // output side: check accepted words and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_rgba_word();
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL bmp_to_rgba_decoder_unit");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_bmp_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < image_bytes.size(); i++)
         send_byte(image_bytes[i], i == image_bytes.size() - 1);
   endtask

   task automatic trim_file(input int keep);
      while (image_bytes.size() > keep) void'(image_bytes.pop_back());
   endtask

   // hold the input until every expected word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // well-formed file: random header filler, gap, padded rows, trailing bytes
   task automatic build_bmp(input logic [7:0] depth, input int w, input int h,
                            input int offset, input int trail);
      int n_ch;
      int row_len;
      image_bytes.delete();
      for (int i = 0; i < HDR_BYTES; i++) image_bytes.push_back(8'($urandom));
      image_bytes[POS_MARK0]  = MARK_B;
      image_bytes[POS_MARK1]  = MARK_M;
      image_bytes[POS_OFS_LO] = offset[7:0];
      image_bytes[POS_OFS_HI] = offset[15:8];
      image_bytes[POS_WID_LO] = w[7:0];
      image_bytes[POS_WID_HI] = w[15:8];
      image_bytes[POS_HGT_LO] = h[7:0];
      image_bytes[POS_HGT_HI] = h[15:8];
      image_bytes[POS_DEPTH]  = depth;
      for (int i = HDR_BYTES; i < offset; i++) image_bytes.push_back(8'($urandom));
      n_ch    = (depth == DEPTH_32) ? 4 : 3;
      row_len = (w * n_ch + 3) & ~3;
      for (int i = 0; i < row_len * h; i++) image_bytes.push_back(8'($urandom));
      for (int i = 0; i < trail; i++) image_bytes.push_back(8'($urandom));
   endtask

   // short, bad marker, bad depth and low offset files
   task automatic test_header_errors();
      image_bytes.delete();
      image_bytes.push_back(MARK_B);
      send_file();
      build_bmp(DEPTH_24, 1, 1, HDR_BYTES, 0);
      trim_file(HDR_BYTES - 1);
      send_file();
      build_bmp(DEPTH_24, 2, 2, HDR_BYTES, 0);
      image_bytes[POS_MARK0] = MARK_M;
      send_file();
      build_bmp(DEPTH_32, 2, 1, HDR_BYTES, 0);
      image_bytes[POS_MARK1] = MARK_B;
      send_file();
      build_bmp(DEPTH_24, 2, 2, HDR_BYTES, 0);
      image_bytes[POS_DEPTH] = DEPTH_16;
      send_file();
      build_bmp(DEPTH_32, 1, 1, HDR_BYTES, 0);
      image_bytes[POS_DEPTH] = 8'hFF;
      send_file();
      build_bmp(DEPTH_24, 2, 2, HDR_BYTES - 1, 0);
      send_file();
      build_bmp(DEPTH_32, 1, 1, 0, 0);
      send_file();
   endtask

   // both depths, padding, gaps, trailing bytes, empty and oversized images
   task automatic test_pixel_layouts();
      build_bmp(DEPTH_24, 3, 2, HDR_BYTES, 0);
      send_file();
      build_bmp(DEPTH_32, 2, 3, HDR_BYTES + 6, 3);
      send_file();
      build_bmp(DEPTH_24, 1, 1, HDR_BYTES + 4, 5);
      send_file();
      build_bmp(DEPTH_24, 0, 3, HDR_BYTES, 2);
      send_file();
      build_bmp(DEPTH_32, 3, 0, HDR_BYTES, 2);
      send_file();
      build_bmp(DEPTH_24, 0, 0, HDR_BYTES, 0);
      send_file();
      // one byte missing from the last row
      build_bmp(DEPTH_24, 3, 2, HDR_BYTES, 0);
      trim_file(image_bytes.size() - 1);
      send_file();
      // full-scale width and height on a short file
      build_bmp(DEPTH_32, 4, 2, HDR_BYTES, 0);
      image_bytes[POS_WID_LO] = 8'hFF;
      image_bytes[POS_WID_HI] = 8'hFF;
      image_bytes[POS_HGT_LO] = 8'hFF;
      image_bytes[POS_HGT_HI] = 8'hFF;
      send_file();
      build_bmp(DEPTH_24, 4, 2, HDR_BYTES, 0);
      image_bytes[POS_OFS_LO] = 8'hFF;
      image_bytes[POS_OFS_HI] = 8'hFF;
      send_file();
      wait_for_drain();
   endtask

   // mostly well-formed files with random content, the rest damaged or noise
   task automatic test_random_files(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int budget);
      int stop_at;
      int keep;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         build_bmp($urandom_range(1) ? DEPTH_32 : DEPTH_24, $urandom_range(5),
                   $urandom_range(4),
                   HDR_BYTES + (($urandom_range(2) == 0) ? $urandom_range(8) : 0),
                   $urandom_range(4));
         if ($urandom_range(99) >= 75) begin
            case ($urandom_range(6))
               0: image_bytes[POS_MARK0] = 8'($urandom);
               1: image_bytes[POS_MARK1] = 8'($urandom);
               2: image_bytes[POS_DEPTH] = 8'($urandom);
               3: begin
                  image_bytes[POS_OFS_LO] = 8'($urandom);
                  image_bytes[POS_OFS_HI] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
               end
               4: image_bytes[$urandom_range(1) ? POS_WID_HI : POS_HGT_HI] = 8'($urandom);
               5: begin
                  keep = $urandom_range(image_bytes.size(), 1);
                  trim_file(keep);
               end
               default: begin
                  image_bytes.delete();
                  repeat ($urandom_range(90, 1)) image_bytes.push_back(8'($urandom));
               end
            endcase
         end
         send_file();
      end
      wait_for_drain();
   endtask

   initial begin
      clear_decoder_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_errors();
      test_pixel_layouts();
      test_random_files(0, 0, 90);
      test_random_files(71, 0, 80);
      test_random_files(0, 71, 80);
      test_random_files(23, 23, 90);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("PASS bmp_to_rgba_decoder_unit");
      end else begin
         $display("FAIL bmp_to_rgba_decoder_unit");
      end
      $finish;
   end

endmodule
